// File: sv/psh_pkg.sv
// ----------------------------------------------------------------------------
// psh_pkg
// shared constants and helpers for the pairwise slope histogram unit
// ----------------------------------------------------------------------------
package psh_pkg;

    localparam int MAX_POINTS_DEF = 1024;
    localparam int RANGE_BINS_DEF = 200;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam int CNT_W = 19;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // quotient request from the pair sweep to the divider
    typedef struct packed {
        logic        valid;
        logic        neg;
        logic [48:0] num;
        logic [32:0] den;
    } div_req_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] ratio;
    } div_rsp_t;

endpackage

// File: sv/pairwise_slope_histogram_unit.sv
// ----------------------------------------------------------------------------
// pairwise_slope_histogram_unit
// slope histogram over all pairs of stored points
// ----------------------------------------------------------------------------
// add: the new point is paired with each stored point in turn, each pair
// with an energy gap waiting on the bit-serial 49-step divider
// read, no-op and clear complete without the divider; clear holds the input
// off during the bin clearing sweep; one item at a time
// result waits in an output register, the next item runs meanwhile
// reset clears the counters at once and sweeps the bin memory before the
// first item is accepted
// ----------------------------------------------------------------------------
module pairwise_slope_histogram_unit
#(
    parameter int MAX_POINTS = psh_pkg::MAX_POINTS_DEF,
    parameter int RANGE_BINS = psh_pkg::RANGE_BINS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic signed [31:0] point_time,
    input  logic signed [31:0] point_energy,
    input  logic [7:0]  bin_index,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        status,
    output logic [18:0] bin_count,
    output logic signed [31:0] min_ratio,
    output logic signed [31:0] max_ratio,
    output logic [18:0] pair_total,
    output logic [18:0] undefined_pairs,
    output logic [10:0] points_held
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int NB = RANGE_BINS + 2;
    localparam int BW = $clog2(NB);
    localparam int PW = $clog2(MAX_POINTS + 1);
    localparam int CW = psh_pkg::CNT_W;
    localparam logic signed [33:0] HALF = 34'sd262144;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_PAIR = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_BIN  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;
    localparam logic [2:0] S_RBIN = 3'd6;
    localparam logic [2:0] S_CLR  = 3'd7;

    logic [2:0]  state_reg;
    logic [1:0]  op_reg;
    logic [31:0] t_reg, e_reg;
    logic [7:0]  idx_reg;
    logic [PW-1:0] np_reg;
    logic [PW-1:0] j_reg;
    logic [CW-1:0] def_reg, zero_reg;
    logic signed [31:0] lo_reg, hi_reg;
    logic        have_reg;
    logic        ovalid_reg;
    logic        status_reg;
    logic [CW-1:0] count_reg;
    logic signed [31:0] r_reg;
    logic signed [31:0] olo_reg, ohi_reg;
    logic [CW-1:0] odef_reg, ozero_reg;
    logic [PW-1:0] onp_reg;

    logic [31:0] st_time, st_energy;
    psh_pkg::div_req_t req;
    psh_pkg::div_rsp_t rsp;
    logic        div_busy;
    logic        clr_busy, inc_busy, clr_start, inc_en;
    logic [BW-1:0] inc_bin, rd_bin;
    logic [CW-1:0] hist_rd;
    logic signed [32:0] dt, de;
    logic [32:0] adt, ade;
    logic signed [33:0] off;
    logic [BW+33:0] prod;
    logic [BW-1:0] bin_calc;
    logic        accept;
    logic        done_go;
    logic        add_full;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE) || clr_busy;
    // a finished item waits here while the previous result is still held
    assign done_go  = (state_reg == S_DONE) && !(ovalid_reg && out_stall);
    assign add_full = (op_reg == psh_pkg::OP_ADD) && (np_reg >= PW'(MAX_POINTS));

    psh_point_store #(.MAX_POINTS(MAX_POINTS)) u_store
    (
        .clk(clk),
        .wr_en(done_go && op_reg == psh_pkg::OP_ADD && !add_full),
        .wr_addr(np_reg[AW-1:0]),
        .wr_time(t_reg),
        .wr_energy(e_reg),
        .rd_addr(j_reg[AW-1:0]),
        .rd_time(st_time),
        .rd_energy(st_energy)
    );

    assign dt  = {t_reg[31], t_reg} - {st_time[31], st_time};
    assign de  = {e_reg[31], e_reg} - {st_energy[31], st_energy};
    assign adt = dt[32] ? 33'd0 - dt : dt;
    assign ade = de[32] ? 33'd0 - de : de;
    assign req.valid = (state_reg == S_PAIR) && (de != 33'sd0);
    assign req.neg   = dt[32] != de[32];
    assign req.num   = {adt, 16'd0};
    assign req.den   = ade;

    psh_divider u_div
    (
        .clk(clk),
        .rst_n(rst_n),
        .req(req),
        .busy(div_busy),
        .rsp(rsp)
    );

    // binning of the registered ratio
    assign off = 34'(r_reg) + HALF;
    assign prod = (BW+34)'(off) * (BW+34)'(RANGE_BINS);
    always_comb
    begin
        if (off < 34'sd0)
            bin_calc = '0;
        else if (off >= 2 * HALF)
            bin_calc = BW'(RANGE_BINS + 1);
        else
            bin_calc = BW'(prod >> 19) + 1'b1;
    end

    assign inc_en    = state_reg == S_BIN;
    assign inc_bin   = bin_calc;
    assign rd_bin    = idx_reg[BW-1:0];
    assign clr_start = accept && operation == psh_pkg::OP_CLEAR;

    psh_histogram #(.RANGE_BINS(RANGE_BINS)) u_hist
    (
        .clk(clk),
        .rst_n(rst_n),
        .clr_start(clr_start),
        .clr_busy(clr_busy),
        .inc_en(inc_en),
        .inc_bin(inc_bin),
        .inc_busy(inc_busy),
        .rd_addr(rd_bin),
        .rd_data(hist_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            np_reg     <= '0;
            j_reg      <= '0;
            r_reg      <= '0;
            def_reg    <= '0;
            zero_reg   <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            have_reg   <= 1'b0;
            status_reg <= 1'b0;
            count_reg  <= '0;
            olo_reg    <= '0;
            ohi_reg    <= '0;
            odef_reg   <= '0;
            ozero_reg  <= '0;
            onp_reg    <= '0;
        end
        else
        begin
            if (done_go)
                ovalid_reg <= 1'b1;
            else if (out_valid && !out_stall)
                ovalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        j_reg <= '0;
                        case (operation)
                            psh_pkg::OP_ADD:
                            begin
                                if (np_reg >= PW'(MAX_POINTS))
                                    state_reg <= S_DONE;
                                else
                                    state_reg <= S_RD;
                            end
                            psh_pkg::OP_READ: state_reg <= S_RBIN;
                            psh_pkg::OP_CLEAR:
                            begin
                                np_reg   <= '0;
                                def_reg  <= '0;
                                zero_reg <= '0;
                                lo_reg   <= '0;
                                hi_reg   <= '0;
                                have_reg <= 1'b0;
                                state_reg <= S_CLR;
                            end
                            default: state_reg <= S_DONE;
                        endcase
                    end
                end
                S_RD:
                begin
                    if (j_reg == np_reg)
                        state_reg <= S_DONE;
                    else
                        state_reg <= S_PAIR;
                end
                S_PAIR:
                begin
                    j_reg <= j_reg + 1'b1;
                    if (de == 33'sd0)
                    begin
                        if (zero_reg != psh_pkg::CNT_MAX)
                            zero_reg <= zero_reg + 1'b1;
                        state_reg <= S_RD;
                    end
                    else
                        state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (rsp.valid)
                    begin
                        r_reg <= rsp.ratio;
                        state_reg <= S_BIN;
                    end
                end
                S_BIN:
                begin
                    if (def_reg != psh_pkg::CNT_MAX)
                        def_reg <= def_reg + 1'b1;
                    have_reg <= 1'b1;
                    if (!have_reg || r_reg < lo_reg)
                        lo_reg <= r_reg;
                    if (!have_reg || r_reg > hi_reg)
                        hi_reg <= r_reg;
                    state_reg <= S_RD;
                end
                S_RBIN:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (done_go)
                    begin
                        status_reg <= add_full;
                        if (op_reg == psh_pkg::OP_READ && idx_reg <= 8'(RANGE_BINS + 1))
                            count_reg <= hist_rd;
                        else
                            count_reg <= '0;
                        if (op_reg == psh_pkg::OP_ADD && !add_full)
                        begin
                            np_reg  <= np_reg + 1'b1;
                            onp_reg <= np_reg + 1'b1;
                        end
                        else
                            onp_reg <= np_reg;
                        olo_reg   <= lo_reg;
                        ohi_reg   <= hi_reg;
                        odef_reg  <= def_reg;
                        ozero_reg <= zero_reg;
                        state_reg <= S_IDLE;
                    end
                end
                S_CLR:
                begin
                    state_reg <= S_DONE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= operation;
            t_reg   <= point_time;
            e_reg   <= point_energy;
            idx_reg <= bin_index;
        end
    end

    assign out_valid       = ovalid_reg;
    assign status          = status_reg;
    assign bin_count       = count_reg;
    assign min_ratio       = olo_reg;
    assign max_ratio       = ohi_reg;
    assign pair_total      = odef_reg;
    assign undefined_pairs = ozero_reg;
    assign points_held     = 11'(onp_reg);

`ifndef SYNTH
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall)
        else $error("transfer accepted while busy");
    a_div_single: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid |-> !div_busy)
        else $error("divider started while running");
    a_inc_spaced: assert property (@(posedge clk) disable iff (!rst_n)
        inc_busy |-> !inc_en)
        else $error("back-to-back bin increments");
    a_points_bound: assert property (@(posedge clk) disable iff (!rst_n)
        np_reg <= PW'(MAX_POINTS))
        else $error("point count beyond store");
`endif

endmodule

// File: sv/psh_divider.sv
// ----------------------------------------------------------------------------
// psh_divider
// radix-2 restoring divider, one quotient bit per cycle, saturates to q16.16
// ----------------------------------------------------------------------------
module psh_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  psh_pkg::div_req_t req,
    output logic              busy,
    output psh_pkg::div_rsp_t rsp
);

    logic [5:0]  cnt_reg, cnt_next;
    logic        run_reg, run_next;
    logic        neg_reg, neg_next;
    logic [48:0] q_reg, q_next;
    logic [32:0] rem_reg, rem_next;
    logic [32:0] den_reg, den_next;
    logic [33:0] trial;
    logic [31:0] sat;
    logic        rsp_valid_reg, rsp_valid_next;
    logic [31:0] ratio_reg, ratio_next;

    assign busy = run_reg;
    assign rsp  = {rsp_valid_reg, ratio_reg};
    assign trial = {rem_reg, q_reg[48]} - {1'b0, den_reg};

    always_comb
    begin
        if (neg_reg)
        begin
            if (q_reg[48:31] != 18'd0)
                sat = 32'h8000_0000;
            else
                sat = 32'd0 - q_reg[31:0];
        end
        else
        begin
            if (q_reg[48:31] != 18'd0)
                sat = 32'h7FFF_FFFF;
            else
                sat = q_reg[31:0];
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        run_next = run_reg;
        neg_next = neg_reg;
        q_next   = q_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        rsp_valid_next = 1'b0;
        ratio_next = ratio_reg;
        if (run_reg)
        begin
            if (cnt_reg == 6'd49)
            begin
                run_next = 1'b0;
                rsp_valid_next = 1'b1;
                ratio_next = sat;
            end
            else
            begin
                cnt_next = cnt_reg + 6'd1;
                if (!trial[33])
                begin
                    rem_next = trial[32:0];
                    q_next   = {q_reg[47:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[31:0], q_reg[48]};
                    q_next   = {q_reg[47:0], 1'b0};
                end
            end
        end
        else if (req.valid)
        begin
            run_next = 1'b1;
            cnt_next = 6'd0;
            neg_next = req.neg;
            q_next   = req.num;
            rem_next = 33'd0;
            den_next = req.den;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            run_reg <= run_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        ratio_reg <= ratio_next;
    end

endmodule

// File: sv/psh_point_store.sv
// ----------------------------------------------------------------------------
// psh_point_store
// time and energy memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module psh_point_store
#(
    parameter int MAX_POINTS = psh_pkg::MAX_POINTS_DEF,
    localparam int AW = $clog2(MAX_POINTS)
)
(
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_time,
    input  logic [31:0]   wr_energy,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_time,
    output logic [31:0]   rd_energy
);

    logic [63:0] mem [MAX_POINTS];
    logic [63:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= {wr_time, wr_energy};
        rd_reg <= mem[rd_addr];
    end

    assign rd_time   = rd_reg[63:32];
    assign rd_energy = rd_reg[31:0];

endmodule

// File: sv/psh_histogram.sv
// ----------------------------------------------------------------------------
// psh_histogram
// bin counter memory with read-modify-write and a clearing sweep
// ----------------------------------------------------------------------------
module psh_histogram
#(
    parameter int RANGE_BINS = psh_pkg::RANGE_BINS_DEF,
    localparam int NB = RANGE_BINS + 2,
    localparam int BW = $clog2(NB)
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   clr_start,
    output logic                   clr_busy,
    input  logic                   inc_en,
    input  logic [BW-1:0]          inc_bin,
    output logic                   inc_busy,
    input  logic [BW-1:0]          rd_addr,
    output logic [psh_pkg::CNT_W-1:0] rd_data
);

    logic [psh_pkg::CNT_W-1:0] mem [NB];
    logic [psh_pkg::CNT_W-1:0] rd_reg;
    logic                      clr_reg;
    logic [BW-1:0]             clr_addr_reg;
    logic                      st1_reg;
    logic [BW-1:0]             bin1_reg;
    logic [BW-1:0]             raddr;

    // increments are spaced by the divider, so no overlap on one entry
    assign raddr    = inc_en ? inc_bin : rd_addr;
    assign rd_data  = rd_reg;
    assign clr_busy = clr_reg;
    assign inc_busy = st1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
            st1_reg      <= 1'b0;
        end
        else
        begin
            st1_reg <= inc_en;
            if (clr_start)
            begin
                clr_reg      <= 1'b1;
                clr_addr_reg <= '0;
            end
            else if (clr_reg)
            begin
                if (clr_addr_reg == BW'(NB - 1))
                    clr_reg <= 1'b0;
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_reg   <= mem[raddr];
        bin1_reg <= inc_bin;
        if (clr_reg)
            mem[clr_addr_reg] <= '0;
        else if (st1_reg && rd_reg != psh_pkg::CNT_MAX)
            mem[bin1_reg] <= rd_reg + 1'b1;
    end

endmodule
